FILE: sv/scd_pkg.sv
// Shared constants and types for the stroke chamfer distance block.
`timescale 1ns / 1ps
package scd_pkg;
    localparam int MAX_DIM    = 128;
    localparam int MAX_PIXELS = 16384;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int DIST_W     = 16;
    localparam int DIM_W      = 8;

    localparam logic [DIST_W-1:0] UNREACH    = 16'hFFFF;
    localparam logic [DIST_W-1:0] STEP_ORTHO = 16'd256;
    localparam logic [DIST_W-1:0] STEP_DIAG  = 16'd362;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
endpackage

FILE: sv/scd_if.sv
// Channel interfaces: command words in, result words out.
`timescale 1ns / 1ps
interface scd_in_if;
    import scd_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [ADDR_W-1:0]   pixel_index;
    logic                mask_bit;
    modport source (output valid, func, pixel_index, mask_bit, input ready);
    modport sink   (input valid, func, pixel_index, mask_bit, output ready);
endinterface

interface scd_out_if;
    import scd_pkg::*;
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance;
    logic                done_res;
    modport source (output valid, distance, done_res, input ready);
    modport sink   (input valid, distance, done_res, output ready);
endinterface

FILE: sv/stroke_chamfer_distance.sv
// Top level of the stroke chamfer distance block: sequencer and two distance RAMs.
`timescale 1ns / 1ps
// Usage
//  in_ch  : command words {func, pixel_index, mask_bit}, valid/ready.
//           func 0 writes a mask pixel, 1 runs the transform, 2 reads a distance.
//  out_ch : one result word per command {distance, done_res}, valid/ready.
//  APB    : image_width at 0x0, image_height at 0x4; write only while idle.
// Sequence
//  Mask write / unknown func: result word registered on acceptance.
//  Distance read: the RAM read lands in S_RD, which loads the output register.
//  Run: mask scan of each active pixel (S_INIT_RD/S_INIT_WR), then per swept pixel
//  S_CTR/S_CWAIT/S_NEXT if settled, plus S_NB/S_NBW for 8 neighbour reads through
//  the single read port and S_WRITE if relaxed, for each sweep of both passes.
// A command is taken only while the sequencer is idle and the output register
// is empty or being emptied, so a stalled receiver simply holds new commands.
// Reset clears control state and the registers (128 x 128); the distance RAMs
// are not cleared and must be written before they are read.
module stroke_chamfer_distance
    import scd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    scd_in_if.sink          in_ch,
    scd_out_if.source       out_ch,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_INIT_RD, S_INIT_WR, S_INIT_END, S_SWEEP,
        S_CTR, S_CWAIT, S_NB, S_NBW, S_WRITE, S_NEXT
    } state_t;

    state_t state_reg;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] w_eff, h_eff, wmax, hmax;
    logic [ADDR_W:0]  npix;
    logic [DIST_W-1:0] limit;

    logic [DIM_W-1:0] x_reg, y_reg;
    logic [DIM_W-1:0] bl_reg, bt_reg, br_reg, bb_reg;   // stroke box
    logic [DIM_W-1:0] sx1_reg, sy1_reg, sx2_reg, sy2_reg; // sweep window
    logic [DIM_W-1:0] ml_reg, mt_reg, mr_reg, mb_reg;   // box during scan
    logic             any_reg, pass_reg, changed_reg, sweep_changed_reg;
    logic [2:0]       k_reg;
    logic             nb_ok_reg;
    logic             nb_last_reg;
    logic [DIST_W-1:0] best_reg, limit_reg;
    logic [ADDR_W-1:0] cur_addr_reg;

    logic              out_valid_reg, out_done_reg;
    logic [DIST_W-1:0] out_dist_reg;

    // RAM ports
    logic              f_we, b_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DIST_W-1:0] f_wdata, b_wdata, f_rdata, b_rdata, sel_rdata;

    logic in_acc, idx_ok;
    logic [DIM_W-1:0] ax, ay, nx, ny;
    logic [2*DIM_W-1:0] prod;
    logic [ADDR_W-1:0] calc_addr;
    logic signed [1:0] dx, dy;
    logic nb_in;
    logic [DIST_W:0] cand;

    // effective dimensions
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < DIM_W'(2)) w_eff = DIM_W'(2);
        if (width_reg > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
        h_eff = height_reg;
        if (height_reg < DIM_W'(2)) h_eff = DIM_W'(2);
        if (height_reg > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
    end
    assign wmax  = w_eff - DIM_W'(1);
    assign hmax  = h_eff - DIM_W'(1);
    assign npix  = (ADDR_W+1)'(w_eff) * (ADDR_W+1)'(h_eff);
    assign limit = (npix >= (ADDR_W+1)'(256)) ? UNREACH : DIST_W'({npix[7:0], 8'd0});

    // neighbour offsets
    always_comb
    begin
        case (k_reg)
            3'd0: begin dx = -2'sd1; dy = -2'sd1; end
            3'd1: begin dx =  2'sd0; dy = -2'sd1; end
            3'd2: begin dx =  2'sd1; dy = -2'sd1; end
            3'd3: begin dx = -2'sd1; dy =  2'sd0; end
            3'd4: begin dx =  2'sd1; dy =  2'sd0; end
            3'd5: begin dx = -2'sd1; dy =  2'sd1; end
            3'd6: begin dx =  2'sd0; dy =  2'sd1; end
            default: begin dx = 2'sd1; dy = 2'sd1; end
        endcase
    end
    assign nx = x_reg + {{(DIM_W-2){dx[1]}}, dx};
    assign ny = y_reg + {{(DIM_W-2){dy[1]}}, dy};
    assign nb_in = !((x_reg == '0) && (dx < 0)) && !((x_reg == wmax) && (dx > 0))
                && !((y_reg == '0) && (dy < 0)) && !((y_reg == hmax) && (dy > 0));

    assign ax = (state_reg == S_NB) ? nx : x_reg;
    assign ay = (state_reg == S_NB) ? ny : y_reg;
    assign prod = ay * w_eff;
    assign calc_addr = prod[ADDR_W-1:0] + ADDR_W'(ax);

    assign in_ch.ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign idx_ok = {1'b0, in_ch.pixel_index} < npix;

    assign sel_rdata = pass_reg ? b_rdata : f_rdata;
    assign cand = {1'b0, sel_rdata} + {1'b0, ((k_reg == 3'd1) || (k_reg == 3'd3)
                  || (k_reg == 3'd4) || (k_reg == 3'd6)) ? STEP_ORTHO : STEP_DIAG};

    // RAM control
    always_comb
    begin
        f_we = 1'b0;
        b_we = 1'b0;
        waddr = cur_addr_reg;
        f_wdata = best_reg;
        b_wdata = best_reg;
        raddr = calc_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                raddr = in_ch.pixel_index;
                waddr = in_ch.pixel_index;
                f_wdata = in_ch.mask_bit ? '0 : UNREACH;
                b_wdata = f_wdata;
                if (in_acc && (in_ch.func == FUNC_WRITE) && idx_ok)
                begin
                    f_we = 1'b1;
                    b_we = 1'b1;
                end
            end
            S_INIT_WR:
            begin
                f_wdata = (f_rdata == '0) ? '0 : UNREACH;
                b_wdata = f_wdata;
                f_we = 1'b1;
                b_we = 1'b1;
            end
            S_WRITE:
            begin
                f_we = !pass_reg && (best_reg < limit_reg);
                b_we =  pass_reg && (best_reg < limit_reg);
            end
            default: ;
        endcase
    end

    scd_ram #(.WIDTH(DIST_W), .DEPTH(MAX_PIXELS)) u_fwd_ram (
        .clk(clk), .we(f_we), .waddr(waddr), .wdata(f_wdata),
        .raddr(raddr), .rdata(f_rdata)
    );
    scd_ram #(.WIDTH(DIST_W), .DEPTH(MAX_PIXELS)) u_bwd_ram (
        .clk(clk), .we(b_we), .waddr(waddr), .wdata(b_wdata),
        .raddr(raddr), .rdata(b_rdata)
    );

    // APB registers
    assign pready = 1'b1;
    assign prdata = {24'd0, (paddr[2] == REG_HEIGHT) ? height_reg : width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(128);
            height_reg <= DIM_W'(128);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_HEIGHT) height_reg <= pwdata[DIM_W-1:0];
            else                        width_reg  <= pwdata[DIM_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [DIM_W-1:0] x1, y1, x2, y2;
        logic last;
        logic load_out;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg <= '0; y_reg <= '0;
            bl_reg <= '0; bt_reg <= '0; br_reg <= '0; bb_reg <= '0;
            sx1_reg <= '0; sy1_reg <= '0; sx2_reg <= '0; sy2_reg <= '0;
            ml_reg <= '0; mt_reg <= '0; mr_reg <= '0; mb_reg <= '0;
            any_reg <= 1'b0; pass_reg <= 1'b0; changed_reg <= 1'b0;
            sweep_changed_reg <= 1'b0;
            k_reg <= '0; nb_ok_reg <= 1'b0; nb_last_reg <= 1'b0;
            best_reg <= '0; limit_reg <= '0; cur_addr_reg <= '0;
            out_valid_reg <= 1'b0; out_done_reg <= 1'b0; out_dist_reg <= '0;
        end
        else
        begin
            load_out = 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (in_ch.func)
                            FUNC_WRITE, FUNC_NONE:
                            begin
                                load_out = 1'b1;
                                out_dist_reg  <= '0;
                                out_done_reg  <= (in_ch.func == FUNC_WRITE);
                            end
                            FUNC_READ:
                            begin
                                any_reg <= idx_ok;
                                state_reg <= S_RD;
                            end
                            default:
                            begin
                                x_reg <= '0; y_reg <= '0;
                                ml_reg <= w_eff; mt_reg <= h_eff;
                                mr_reg <= '0; mb_reg <= '0;
                                any_reg <= 1'b0; pass_reg <= 1'b0;
                                limit_reg <= limit;
                                state_reg <= S_INIT_RD;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    load_out = 1'b1;
                    out_done_reg  <= 1'b1;
                    out_dist_reg  <= !any_reg ? UNREACH :
                                     (f_rdata < b_rdata) ? f_rdata : b_rdata;
                    state_reg <= S_IDLE;
                end
                S_INIT_RD:
                begin
                    cur_addr_reg <= calc_addr;
                    state_reg <= S_INIT_WR;
                end
                S_INIT_WR:
                begin
                    if (f_rdata == '0)
                    begin
                        any_reg <= 1'b1;
                        if (x_reg < ml_reg) ml_reg <= x_reg;
                        if (y_reg < mt_reg) mt_reg <= y_reg;
                        if (x_reg > mr_reg) mr_reg <= x_reg;
                        if (y_reg > mb_reg) mb_reg <= y_reg;
                    end
                    if (x_reg == wmax)
                    begin
                        x_reg <= '0;
                        y_reg <= y_reg + DIM_W'(1);
                        state_reg <= (y_reg == hmax) ? S_INIT_END : S_INIT_RD;
                    end
                    else
                    begin
                        x_reg <= x_reg + DIM_W'(1);
                        state_reg <= S_INIT_RD;
                    end
                end
                S_INIT_END:
                begin
                    if (!any_reg)
                    begin
                        bl_reg <= '0; bt_reg <= '0; br_reg <= '0; bb_reg <= '0;
                        sweep_changed_reg <= 1'b0;
                        load_out = 1'b1; out_done_reg <= 1'b1; out_dist_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        bl_reg <= ml_reg; bt_reg <= mt_reg; br_reg <= mr_reg; bb_reg <= mb_reg;
                        sx1_reg <= ml_reg; sy1_reg <= mt_reg;
                        sx2_reg <= mr_reg; sy2_reg <= mb_reg;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    // widen the window by one pixel each side
                    x1 = (sx1_reg != '0) ? sx1_reg - DIM_W'(1) : sx1_reg;
                    y1 = (sy1_reg != '0) ? sy1_reg - DIM_W'(1) : sy1_reg;
                    x2 = (sx2_reg < wmax) ? sx2_reg + DIM_W'(1) : sx2_reg;
                    y2 = (sy2_reg < hmax) ? sy2_reg + DIM_W'(1) : sy2_reg;
                    sx1_reg <= x1; sy1_reg <= y1; sx2_reg <= x2; sy2_reg <= y2;
                    changed_reg <= 1'b0;
                    x_reg <= pass_reg ? x2 : x1;
                    y_reg <= pass_reg ? y2 : y1;
                    state_reg <= S_CTR;
                end
                S_CTR:
                begin
                    cur_addr_reg <= calc_addr;
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    k_reg <= '0;
                    best_reg <= limit_reg;
                    state_reg <= (sel_rdata == UNREACH) ? S_NB : S_NEXT;
                end
                S_NB:
                begin
                    nb_ok_reg <= nb_in;
                    nb_last_reg <= (k_reg == 3'd7);
                    state_reg <= S_NBW;
                end
                S_NBW:
                begin
                    if (nb_ok_reg && (cand < {1'b0, best_reg}))
                        best_reg <= cand[DIST_W-1:0];
                    k_reg <= k_reg + 3'd1;
                    state_reg <= nb_last_reg ? S_WRITE : S_NB;
                end
                S_WRITE:
                begin
                    if (best_reg < limit_reg) changed_reg <= 1'b1;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    last = 1'b0;
                    if (!pass_reg)
                    begin
                        if (x_reg == sx2_reg)
                        begin
                            x_reg <= sx1_reg;
                            y_reg <= y_reg + DIM_W'(1);
                            last = (y_reg == sy2_reg);
                        end
                        else x_reg <= x_reg + DIM_W'(1);
                    end
                    else
                    begin
                        if (x_reg == sx1_reg)
                        begin
                            x_reg <= sx2_reg;
                            y_reg <= y_reg - DIM_W'(1);
                            last = (y_reg == sy1_reg);
                        end
                        else x_reg <= x_reg - DIM_W'(1);
                    end
                    if (!last) state_reg <= S_CTR;
                    else
                    begin
                        sweep_changed_reg <= changed_reg;
                        if (changed_reg) state_reg <= S_SWEEP;
                        else if (!pass_reg)
                        begin
                            pass_reg <= 1'b1;
                            sx1_reg <= bl_reg; sy1_reg <= bt_reg;
                            sx2_reg <= br_reg; sy2_reg <= bb_reg;
                            state_reg <= S_SWEEP;
                        end
                        else
                        begin
                            load_out = 1'b1; out_done_reg <= 1'b1;
                            out_dist_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // a new result word wins over the word being taken this cycle
            if (load_out) out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.distance = out_dist_reg;
    assign out_ch.done_res = out_done_reg;
endmodule

FILE: sv/scd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module scd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: verif/tb_stroke_chamfer_distance.sv
// Testbench for stroke_chamfer_distance: mask loads, transform runs and distance reads.
`timescale 1ns / 1ps
module tb_stroke_chamfer_distance;
    import scd_pkg::*;

    // Longest stretch with no word accepted on either side. A run on a
    // 128 x 2 image takes about 127 sweeps per pass, so this is sized to
    // allow the slowest transform.
    localparam int STALL_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        func_t             func;
        logic [ADDR_W-1:0] pixel_index;
        logic              mask_bit;
    } cmd_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              done_res;
    } result_word_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    scd_in_if  in_ch ();
    scd_out_if out_ch ();

    stroke_chamfer_distance u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Command words waiting to go in, results waiting to come out.
    cmd_word_t    cmd_queue[$];
    result_word_t expected_results[$];

    // Own copy of the block's state.
    bit [15:0] fwd_map[MAX_PIXELS];
    bit [15:0] bwd_map[MAX_PIXELS];
    bit [15:0] work_map[MAX_PIXELS];
    bit        written[MAX_PIXELS];
    int        cfg_width  = 128;
    int        cfg_height = 128;
    int        box_l, box_t, box_r, box_b;

    int  errors = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  idling_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Reference arithmetic
    // ------------------------------------------------------------------
    function automatic int active_width();
        int w;
        w = cfg_width;
        if (w < 2) w = 2;
        if (w > MAX_DIM) w = MAX_DIM;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        int w;
        w = active_width();
        h = cfg_height;
        if (h < 2) h = 2;
        if (h > MAX_DIM) h = MAX_DIM;
        if (h > MAX_PIXELS / w) h = MAX_PIXELS / w;
        return h;
    endfunction

    // An unreachable pixel takes its cheapest reachable neighbour plus the step.
    function automatic bit settle_pixel(int x, int y, int w, int h, int lim);
        int best;
        int c;
        int nx;
        int ny;
        best = lim;
        if (work_map[y*w+x] != UNREACH) return 1'b0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
            begin
                nx = x + dx;
                ny = y + dy;
                if (dx == 0 && dy == 0) continue;
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                c = int'(work_map[ny*w+nx]) +
                    ((dx != 0 && dy != 0) ? int'(STEP_DIAG) : int'(STEP_ORTHO));
                if (c < best) best = c;
            end
        if (best < lim)
        begin
            work_map[y*w+x] = best[15:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Growing-box sweeps over work_map until one changes nothing.
    function automatic void sweep_pass(int w, int h, int lim, bit rev);
        int x1, y1, x2, y2;
        bit changed;
        x1 = box_l; y1 = box_t; x2 = box_r; y2 = box_b;
        changed = 1'b1;
        while (changed)
        begin
            changed = 1'b0;
            if (x1 > 0) x1--;
            if (y1 > 0) y1--;
            if (x2 < w - 1) x2++;
            if (y2 < h - 1) y2++;
            if (!rev)
            begin
                for (int y = y1; y <= y2; y++)
                    for (int x = x1; x <= x2; x++)
                        if (settle_pixel(x, y, w, h, lim)) changed = 1'b1;
            end
            else
            begin
                for (int y = y2; y >= y1; y--)
                    for (int x = x2; x >= x1; x--)
                        if (settle_pixel(x, y, w, h, lim)) changed = 1'b1;
            end
        end
    endfunction

    function automatic void chamfer_transform();
        int w, h, lim, i;
        bit any;
        w = active_width();
        h = active_height();
        lim = w * h * 256;
        if (lim > int'(UNREACH)) lim = int'(UNREACH);
        any = 1'b0;
        box_l = w; box_t = h; box_r = 0; box_b = 0;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                i = y * w + x;
                if (fwd_map[i] == 16'd0)
                begin
                    any = 1'b1;
                    if (x < box_l) box_l = x;
                    if (y < box_t) box_t = y;
                    if (x > box_r) box_r = x;
                    if (y > box_b) box_b = y;
                    bwd_map[i] = 16'd0;
                end
                else
                begin
                    fwd_map[i] = UNREACH;
                    bwd_map[i] = UNREACH;
                end
            end
        if (!any)
        begin
            box_l = 0; box_t = 0; box_r = 0; box_b = 0;
            return;
        end
        work_map = fwd_map;
        sweep_pass(w, h, lim, 1'b0);
        fwd_map = work_map;
        work_map = bwd_map;
        sweep_pass(w, h, lim, 1'b1);
        bwd_map = work_map;
    endfunction

    function automatic result_word_t apply_command(cmd_word_t c);
        result_word_t r;
        int n;
        bit in_range;
        n = active_width() * active_height();
        in_range = int'(c.pixel_index) < n;
        r.distance = '0;
        r.done_res = 1'b1;
        case (c.func)
            FUNC_WRITE:
                if (in_range)
                begin
                    fwd_map[c.pixel_index] = c.mask_bit ? 16'd0 : UNREACH;
                    bwd_map[c.pixel_index] = c.mask_bit ? 16'd0 : UNREACH;
                end
            FUNC_RUN:
                chamfer_transform();
            FUNC_READ:
                if (in_range)
                    r.distance = (fwd_map[c.pixel_index] < bwd_map[c.pixel_index]) ?
                                 fwd_map[c.pixel_index] : bwd_map[c.pixel_index];
                else
                    r.distance = UNREACH;
            default:
                r.done_res = 1'b0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: bursts of idling, never drops valid while holding
    // ------------------------------------------------------------------
    int  send_gap;
    bit  fire_in;
    bit  holding;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.func        <= FUNC_WRITE;
            in_ch.pixel_index <= '0;
            in_ch.mask_bit    <= 1'b0;
            send_gap          = 0;
        end
        else
        begin
            fire_in = in_ch.valid && in_ch.ready;
            if (fire_in)
            begin
                expected_results.push_back(apply_command(cmd_queue[0]));
                cmd_queue.pop_front();
            end
            holding = in_ch.valid && !fire_in;
            if (holding)
            begin
                // keep the word on the bus until taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                if (idling_on && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 15);
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    in_ch.valid       <= 1'b1;
                    in_ch.func        <= cmd_queue[0].func;
                    in_ch.pixel_index <= cmd_queue[0].pixel_index;
                    in_ch.mask_bit    <= cmd_queue[0].mask_bit;
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    int  sink_gap;
    int  long_hold;
    bit  long_hold_done;
    result_word_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready   <= 1'b0;
            sink_gap       = 0;
            long_hold      = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word distance=%0d done=%0b",
                             $time, out_ch.distance, out_ch.done_res);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.distance !== want.distance)
                    begin
                        errors++;
                        $display("%0t: distance expected %0d got %0d",
                                 $time, want.distance, out_ch.distance);
                    end
                    if (out_ch.done_res !== want.done_res)
                    begin
                        errors++;
                        $display("%0t: done_res expected %0b got %0b",
                                 $time, want.done_res, out_ch.done_res);
                    end
                end
            end
            // one long stall mid-run so the block backs up onto its input
            if (!long_hold_done && results_seen == 150)
            begin
                long_hold_done = 1'b1;
                long_hold = 300;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(1, 15);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_cmd(func_t f, int idx, bit m);
        cmd_word_t c;
        c.func = f;
        c.pixel_index = idx[ADDR_W-1:0];
        c.mask_bit = m;
        cmd_queue.push_back(c);
    endtask

    task automatic wait_quiet();
        while (cmd_queue.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge clk);
    endtask

    task automatic apb_write(logic reg_sel, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_WIDTH) cfg_width = value & 8'hFF;
        else cfg_height = value & 8'hFF;
    endtask

    // New geometry: program it, then load every active pixel not yet written.
    task automatic set_geometry(int w, int h, bit stroke_rand);
        int n;
        wait_quiet();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        n = active_width() * active_height();
        for (int i = 0; i < n; i++)
            if (!written[i])
            begin
                written[i] = 1'b1;
                push_cmd(FUNC_WRITE, i, stroke_rand && ($urandom_range(0, 19) == 0));
            end
    endtask

    task automatic random_words(int count, int runs_allowed);
        int n, r;
        n = active_width() * active_height();
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                push_cmd(FUNC_WRITE, $urandom_range(0, n - 1), $urandom_range(0, 9) < 3);
            else if (r < 46)
                push_cmd(FUNC_WRITE, $urandom_range(0, MAX_PIXELS - 1),
                         1'($urandom_range(0, 1)));
            else if (r < 84)
                push_cmd(FUNC_READ, $urandom_range(0, n - 1), 1'($urandom_range(0, 1)));
            else if (r < 91)
                push_cmd(FUNC_READ, $urandom_range(0, MAX_PIXELS - 1),
                         1'($urandom_range(0, 1)));
            else if (r < 95)
                push_cmd(FUNC_NONE, $urandom_range(0, MAX_PIXELS - 1),
                         1'($urandom_range(0, 1)));
            else if (runs_allowed > 0)
            begin
                runs_allowed--;
                push_cmd(FUNC_RUN, $urandom_range(0, MAX_PIXELS - 1),
                         1'($urandom_range(0, 1)));
            end
            else
                push_cmd(FUNC_READ, $urandom_range(0, n - 1), 1'b0);
        end
        // always finish a phase with a transform and a look at its result
        if (runs_allowed >= 0)
        begin
            push_cmd(FUNC_RUN, 0, 1'b0);
            for (int k = 0; k < 12; k++)
                push_cmd(FUNC_READ, $urandom_range(0, n - 1), 1'b0);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // 4 x 3 image, all background: empty-mask run first
        set_geometry(4, 3, 1'b0);
        push_cmd(FUNC_RUN, 0, 1'b0);
        push_cmd(FUNC_READ, 0, 1'b0);
        push_cmd(FUNC_READ, 11, 1'b1);
        push_cmd(FUNC_READ, 12, 1'b0);          // just past the image
        push_cmd(FUNC_READ, MAX_PIXELS - 1, 1'b1);
        push_cmd(FUNC_NONE, MAX_PIXELS - 1, 1'b1);
        push_cmd(FUNC_WRITE, 12, 1'b1);         // ignored, out of range
        push_cmd(FUNC_WRITE, 0, 1'b1);          // stroke in a corner
        push_cmd(FUNC_RUN, 0, 1'b0);
        push_cmd(FUNC_READ, 11, 1'b0);
        push_cmd(FUNC_READ, 5, 1'b0);
        push_cmd(FUNC_READ, 0, 1'b0);
        push_cmd(FUNC_WRITE, 11, 1'b1);
        push_cmd(FUNC_WRITE, 0, 1'b0);
        push_cmd(FUNC_RUN, MAX_PIXELS - 1, 1'b1);
        push_cmd(FUNC_READ, 0, 1'b0);
        push_cmd(FUNC_READ, 6, 1'b0);
        random_words(20, 3);

        // width below the clamp, then the widest and the tallest images
        set_geometry(0, 5, 1'b1);
        random_words(20, 3);
        set_geometry(255, 2, 1'b1);
        random_words(15, 0);
        set_geometry(2, 255, 1'b1);
        random_words(15, 0);
        set_geometry(9, 7, 1'b1);
        random_words(15, 2);

        // tail of the run at full rate
        wait_quiet();
        idling_on = 1'b0;
        set_geometry(6, 4, 1'b1);
        random_words(15, 2);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
